/* hw/rtl/bpst_pkg.sv */
`timescale 1ns / 1ps

package bpst_pkg;

   // phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_READY  = 3'd1;
   localparam logic [2:0] PH_INHALE = 3'd2;
   localparam logic [2:0] PH_HOLD   = 3'd3;
   localparam logic [2:0] PH_EXHALE = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_CYCLE0  = 3'd0;
   localparam logic [2:0] CSR_CYCLE1  = 3'd1;
   localparam logic [2:0] CSR_CYCLE2  = 3'd2;
   localparam logic [2:0] CSR_CYCLE3  = 3'd3;
   localparam logic [2:0] CSR_READY   = 3'd4;
   localparam logic [2:0] CSR_CAPTION = 3'd5;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_TAP  = 1'b1;

   localparam logic [23:0] CYCLE0_RESET  = 24'h040302;
   localparam logic [23:0] CYCLE1_RESET  = 24'h060503;
   localparam logic [23:0] CYCLE2_RESET  = 24'h080704;
   localparam logic [23:0] CYCLE3_RESET  = 24'h080704;
   localparam logic [7:0]  READY_RESET   = 8'd3;
   localparam logic [15:0] CAPTION_RESET = 16'd2000;
   localparam logic [17:0] MAX_PHASE_MS  = 18'd255000;

   typedef struct packed {
      logic        operation;
      logic [15:0] tick_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  phase_code;
      logic        is_running;
      logic        in_session;
      logic [1:0]  current_cycle;
      logic [17:0] phase_left_ms;
      logic [17:0] phase_length_ms;
      logic [15:0] caption_left_ms;
   } rsp_type;

   typedef struct packed {
      logic load;   // latch the accepted beat, apply tap or caption update
      logic step;   // one phase advance, or the final subtraction
      logic emit;   // capture status into the response register
   } bpst_cmd_type;

   typedef struct packed {
      logic more;   // the tick still covers the whole current phase
   } bpst_status_type;

   function automatic logic [17:0] sec_to_ms(input logic [7:0] sec);
      return 18'(sec) * 18'd1000;
   endfunction

endpackage

/* hw/rtl/bpst_ctrl.sv */
`timescale 1ns / 1ps

module bpst_ctrl
   import bpst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  bpst_status_type status,
   output bpst_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (!status.more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_walks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_WALK))
      else $error("accepted beat did not start a walk");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && slot_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending response dropped");
`endif

endmodule

/* hw/rtl/bpst_datapath.sv */
`timescale 1ns / 1ps

module bpst_datapath
   import bpst_pkg::*;
#(
   parameter int NUM_CYCLES = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  logic            csr_write,
   input  logic [2:0]      csr_index,
   input  logic [23:0]     csr_data,
   input  bpst_cmd_type    cmd,
   output bpst_status_type status,
   output rsp_type         rsp_data
);

   logic [23:0] cycle_cfg_ff [4];
   logic [23:0] cycle_cfg_in [4];
   logic [7:0]  ready_cfg_ff, ready_cfg_in;
   logic [15:0] caption_cfg_ff, caption_cfg_in;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  cyc_ff, cyc_in;
   logic [17:0] remaining_ff, remaining_in;
   logic        running_ff, running_in;
   logic [15:0] caption_ff, caption_in;
   logic        tick_ff, tick_in;
   logic [15:0] dt_ff, dt_in;
   rsp_type     rsp_data_ff;

   logic [2:0]  cyc_plus;
   logic        last_cycle;
   logic [1:0]  adv_cyc;
   logic [1:0]  adv_part;
   logic [17:0] adv_ms;
   logic [17:0] full_ms;
   logic        covers;

   function automatic logic [7:0] part_sec(input logic [23:0] word, input logic [1:0] part);
      logic [7:0] sec;
      unique case (part)
         2'd0:    sec = word[7:0];
         2'd1:    sec = word[15:8];
         default: sec = word[23:16];
      endcase
      return sec;
   endfunction

   assign cyc_plus   = {1'b0, cyc_ff} + 3'd1;
   assign last_cycle = (cyc_plus >= 3'(NUM_CYCLES));
   assign covers     = ({2'b00, dt_ff} >= remaining_ff);
   assign status.more = tick_ff && running_ff && covers;

   // which part of which cycle the next phase takes its length from
   always_comb begin
      adv_cyc  = cyc_ff;
      adv_part = 2'd0;
      unique case (phase_ff)
         PH_INHALE: adv_part = 2'd1;
         PH_HOLD:   adv_part = 2'd2;
         PH_EXHALE: adv_cyc  = cyc_plus[1:0];
         default:   adv_part = 2'd0;
      endcase
   end

   assign adv_ms = sec_to_ms(part_sec(cycle_cfg_ff[adv_cyc], adv_part));

   always_comb begin
      unique case (phase_ff)
         PH_READY:  full_ms = sec_to_ms(ready_cfg_ff);
         PH_INHALE: full_ms = sec_to_ms(part_sec(cycle_cfg_ff[cyc_ff], 2'd0));
         PH_HOLD:   full_ms = sec_to_ms(part_sec(cycle_cfg_ff[cyc_ff], 2'd1));
         PH_EXHALE: full_ms = sec_to_ms(part_sec(cycle_cfg_ff[cyc_ff], 2'd2));
         default:   full_ms = '0;
      endcase
   end

   always_comb begin
      cycle_cfg_in   = cycle_cfg_ff;
      ready_cfg_in   = ready_cfg_ff;
      caption_cfg_in = caption_cfg_ff;
      phase_in       = phase_ff;
      cyc_in         = cyc_ff;
      remaining_in   = remaining_ff;
      running_in     = running_ff;
      caption_in     = caption_ff;
      tick_in        = tick_ff;
      dt_in          = dt_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_CYCLE0:  cycle_cfg_in[0] = csr_data;
            CSR_CYCLE1:  cycle_cfg_in[1] = csr_data;
            CSR_CYCLE2:  cycle_cfg_in[2] = csr_data;
            CSR_CYCLE3:  cycle_cfg_in[3] = csr_data;
            CSR_READY:   ready_cfg_in    = csr_data[7:0];
            CSR_CAPTION: caption_cfg_in  = csr_data[15:0];
            default:     ;
         endcase
      end

      if (cmd.load) begin
         tick_in = (req_data.operation == OP_TICK);
         dt_in   = req_data.tick_ms;
         if (req_data.operation == OP_TAP) begin
            if (phase_ff == PH_IDLE) begin
               cyc_in       = 2'd0;
               phase_in     = PH_READY;
               remaining_in = sec_to_ms(ready_cfg_ff);
               running_in   = 1'b1;
            end else begin
               running_in = !running_ff;
            end
         end else begin
            // caption saturates at zero, runs in every state
            caption_in = (req_data.tick_ms < caption_ff) ?
                         caption_ff - req_data.tick_ms : 16'd0;
         end
      end

      if (cmd.step && tick_ff && running_ff) begin
         if (covers) begin
            dt_in = dt_ff - remaining_ff[15:0];
            unique case (phase_ff)
               PH_READY: begin
                  phase_in     = PH_INHALE;
                  remaining_in = adv_ms;
               end
               PH_INHALE: begin
                  phase_in     = PH_HOLD;
                  remaining_in = adv_ms;
               end
               PH_HOLD: begin
                  phase_in     = PH_EXHALE;
                  remaining_in = adv_ms;
               end
               PH_EXHALE: begin
                  if (last_cycle) begin
                     // session over; remaining is left as it was
                     phase_in   = PH_IDLE;
                     cyc_in     = 2'd0;
                     running_in = 1'b0;
                     caption_in = caption_cfg_ff;
                  end else begin
                     phase_in     = PH_INHALE;
                     cyc_in       = adv_cyc;
                     remaining_in = adv_ms;
                  end
               end
               default: begin
                  running_in = 1'b0;
               end
            endcase
         end else begin
            remaining_in = remaining_ff - {2'b00, dt_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_cfg_ff[0] <= CYCLE0_RESET;
         cycle_cfg_ff[1] <= CYCLE1_RESET;
         cycle_cfg_ff[2] <= CYCLE2_RESET;
         cycle_cfg_ff[3] <= CYCLE3_RESET;
         ready_cfg_ff    <= READY_RESET;
         caption_cfg_ff  <= CAPTION_RESET;
         phase_ff        <= PH_IDLE;
         cyc_ff          <= 2'd0;
         remaining_ff    <= '0;
         running_ff      <= 1'b0;
         caption_ff      <= '0;
         tick_ff         <= 1'b0;
      end else begin
         cycle_cfg_ff    <= cycle_cfg_in;
         ready_cfg_ff    <= ready_cfg_in;
         caption_cfg_ff  <= caption_cfg_in;
         phase_ff        <= phase_in;
         cyc_ff          <= cyc_in;
         remaining_ff    <= remaining_in;
         running_ff      <= running_in;
         caption_ff      <= caption_in;
         tick_ff         <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      if (cmd.emit) begin
         rsp_data_ff.phase_code      <= phase_ff;
         rsp_data_ff.is_running      <= running_ff;
         rsp_data_ff.in_session      <= (phase_ff != PH_IDLE);
         rsp_data_ff.current_cycle   <= cyc_ff;
         rsp_data_ff.phase_left_ms   <= remaining_ff;
         rsp_data_ff.phase_length_ms <= full_ms;
         rsp_data_ff.caption_left_ms <= caption_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_run_has_phase: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (phase_ff != PH_IDLE))
      else $error("running without a phase");

   a_cycle_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cyc_ff} < 3'(NUM_CYCLES)))
      else $error("cycle index beyond session length");

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      (remaining_ff <= MAX_PHASE_MS))
      else $error("remaining time exceeds longest phase");
`endif

endmodule

/* hw/rtl/breathing_phase_sequencer_timer.sv */
`timescale 1ns / 1ps

// Breathing phase sequencer timer.
// req channel: one beat is either a tick carrying elapsed milliseconds or a
// tap (start when idle, otherwise pause/resume). Each beat gives exactly one
// rsp beat with the status after the update.
// csr channel: index/data writes to the duration registers; always ready.
// Write it only while no item is in flight.
// Flow: accept, one walk step per phase boundary the tick crosses plus
// a closing step (the final subtraction for a running tick), then a load
// of the response register. A tap crosses no boundary; a tick crosses at
// most 13 with four breathing cycles. The walk is one phase advance per clock
// through the shared length lookup and x1000 scaler.
// A new req beat is taken once the previous item has reached the response
// register, even while that response is still waiting to be taken.
// If a response is still pending and rsp_ready stays low, the finished status
// waits in the done state and req_ready stays low until the response register frees up.
// Synchronous reset: idle phase, caption countdown zero, registers back to
// their default durations, no response pending.
module breathing_phase_sequencer_timer
   import bpst_pkg::*;
#(
   parameter int NUM_CYCLES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   bpst_cmd_type    cmd;
   bpst_status_type status;

   assign csr_ready = 1'b1;

   bpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpst_datapath #(
      .NUM_CYCLES (NUM_CYCLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/breathing_phase_sequencer_timer_test.sv */
`timescale 1ns / 1ps

module breathing_phase_sequencer_timer_test;
   import bpst_pkg::*;

   localparam int NUM_CYCLES  = 4;
   localparam int PHASE_ITEMS = 210;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MS_PER_SEC  = 1000;

   // indexes past the register file, writes to them must be dropped
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data  = '0;

   breathing_phase_sequencer_timer #(
      .NUM_CYCLES(NUM_CYCLES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // shadow of the sequencer: registers and session state
   logic [23:0] cycle_secs [4];
   logic [7:0]  ready_secs;
   logic [15:0] caption_len;
   logic [2:0]  m_phase;
   logic [1:0]  m_cycle;
   logic        m_running;
   int unsigned m_left;
   int unsigned m_caption;

   rsp_type     status_due [$];
   int          errors    = 0;
   int          idle_pct  = 0;
   int          stall_pct = 0;

   typedef struct {
      bit          is_reg;
      logic [2:0]  idx;
      logic [23:0] val;
      req_type     item;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   plan_row_type plan [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic int unsigned part_ms(input logic [1:0] cyc, input int part);
      return int'(cycle_secs[cyc][8*part +: 8]) * MS_PER_SEC;
   endfunction

   function automatic int unsigned phase_len_ms();
      case (m_phase)
         PH_READY:  return int'(ready_secs) * MS_PER_SEC;
         PH_INHALE: return part_ms(m_cycle, 0);
         PH_HOLD:   return part_ms(m_cycle, 1);
         PH_EXHALE: return part_ms(m_cycle, 2);
         default:   return 0;
      endcase
   endfunction

   task automatic next_phase();
      case (m_phase)
         PH_READY: begin
            m_phase = PH_INHALE;
            m_left  = part_ms(m_cycle, 0);
         end
         PH_INHALE: begin
            m_phase = PH_HOLD;
            m_left  = part_ms(m_cycle, 1);
         end
         PH_HOLD: begin
            m_phase = PH_EXHALE;
            m_left  = part_ms(m_cycle, 2);
         end
         PH_EXHALE: begin
            if (int'(m_cycle) + 1 >= NUM_CYCLES) begin
               // session over: remaining time is left as it was
               m_phase   = PH_IDLE;
               m_cycle   = '0;
               m_running = 1'b0;
               m_caption = caption_len;
            end else begin
               m_cycle = m_cycle + 2'd1;
               m_phase = PH_INHALE;
               m_left  = part_ms(m_cycle, 0);
            end
         end
         default: m_running = 1'b0;
      endcase
   endtask

   task automatic step_sequencer(input req_type item, output rsp_type st);
      int unsigned dt;
      dt = item.tick_ms;
      if (item.operation == OP_TAP) begin
         if (m_phase == PH_IDLE) begin
            m_cycle   = '0;
            m_phase   = PH_READY;
            m_left    = int'(ready_secs) * MS_PER_SEC;
            m_running = 1'b1;
         end else begin
            m_running = ~m_running;
         end
      end else begin
         if (m_caption > 0)
            m_caption = (dt < m_caption) ? m_caption - dt : 0;
         // walk every boundary the tick covers, zero-length phases too
         while (m_running && dt >= m_left) begin
            dt -= m_left;
            next_phase();
         end
         if (m_running)
            m_left -= dt;
      end
      st.phase_code      = m_phase;
      st.is_running      = m_running;
      st.in_session      = (m_phase != PH_IDLE);
      st.current_cycle   = m_cycle;
      st.phase_left_ms   = 18'(m_left);
      st.phase_length_ms = 18'(phase_len_ms());
      st.caption_left_ms = 16'(m_caption);
   endtask

   task automatic apply_reg(input logic [2:0] idx, input logic [23:0] val);
      case (idx)
         CSR_CYCLE0:  cycle_secs[0] = val;
         CSR_CYCLE1:  cycle_secs[1] = val;
         CSR_CYCLE2:  cycle_secs[2] = val;
         CSR_CYCLE3:  cycle_secs[3] = val;
         CSR_READY:   ready_secs    = val[7:0];
         CSR_CAPTION: caption_len   = val[15:0];
         default: ;
      endcase
   endtask

   function automatic rsp_type shown(input logic [2:0] ph, input logic run,
                                     input logic [1:0] cyc, input logic [17:0] left,
                                     input logic [17:0] len, input logic [15:0] cap);
      rsp_type st;
      st.phase_code      = ph;
      st.is_running      = run;
      st.in_session      = (ph != PH_IDLE);
      st.current_cycle   = cyc;
      st.phase_left_ms   = left;
      st.phase_length_ms = len;
      st.caption_left_ms = cap;
      return st;
   endfunction

   task automatic plan_item(input logic op, input logic [15:0] ms);
      plan_row_type row;
      row = '{default: '0};
      row.item.operation = op;
      row.item.tick_ms   = ms;
      plan.push_back(row);
   endtask

   task automatic plan_check(input logic op, input logic [15:0] ms, input rsp_type want);
      plan_row_type row;
      row = '{default: '0};
      row.item.operation = op;
      row.item.tick_ms   = ms;
      row.typed          = 1'b1;
      row.want           = want;
      plan.push_back(row);
   endtask

   task automatic plan_reg(input logic [2:0] idx, input logic [23:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.is_reg = 1'b1;
      row.idx    = idx;
      row.val    = val;
      plan.push_back(row);
   endtask

   // drop both valids and let every outstanding status beat drain
   task automatic hold_off();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type predicted;
      csr_valid <= 1'b0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      step_sequencer(item, predicted);
      status_due.push_back(typed ? want : predicted);
   endtask

   function automatic logic [23:0] rand_cycle_word(input bit wide);
      logic [23:0] w;
      int          r;
      if (wide)
         return 24'($urandom);
      for (int b = 0; b < 3; b++) begin
         r = $urandom_range(0, 19);
         if (r < 4)
            w[8*b +: 8] = 8'd0;
         else if (r < 18)
            w[8*b +: 8] = 8'($urandom_range(1, 3));
         else
            w[8*b +: 8] = 8'($urandom_range(4, 255));
      end
      return w;
   endfunction

   // mostly whole sessions; ticks often land right on a phase boundary
   function automatic req_type next_random_item();
      req_type item;
      int      r;
      item.tick_ms = 16'($urandom);
      r = $urandom_range(0, 99);
      if (m_phase == PH_IDLE)
         item.operation = (r < 60) ? OP_TAP : OP_TICK;
      else if (!m_running)
         item.operation = (r < 50) ? OP_TAP : OP_TICK;
      else
         item.operation = (r < 4) ? OP_TAP : OP_TICK;
      if (item.operation == OP_TICK) begin
         r = $urandom_range(0, 99);
         if (m_running && r < 25)
            item.tick_ms = (m_left > 65535) ? 16'hFFFF : 16'(m_left);
         else if (m_running && r < 35 && m_left != 0)
            item.tick_ms = (m_left > 65536) ? 16'hFFFF : 16'(m_left - 1);
         else if (r < 60)
            item.tick_ms = 16'($urandom_range(0, 1500));
         else if (r < 75)
            item.tick_ms = 16'hFFFF;
         else if (r >= 90)
            item.tick_ms = 16'h0000;
      end
      return item;
   endfunction

   // status checker and receiver back-pressure
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            report_mismatch($sformatf("status beat %h with nothing expected", rsp_data));
         end else begin
            want = status_due.pop_front();
            if (rsp_data.phase_code !== want.phase_code)
               report_mismatch($sformatf("phase_code %0d, want %0d",
                                         rsp_data.phase_code, want.phase_code));
            if (rsp_data.is_running !== want.is_running)
               report_mismatch($sformatf("is_running %0d, want %0d",
                                         rsp_data.is_running, want.is_running));
            if (rsp_data.in_session !== want.in_session)
               report_mismatch($sformatf("in_session %0d, want %0d",
                                         rsp_data.in_session, want.in_session));
            if (rsp_data.current_cycle !== want.current_cycle)
               report_mismatch($sformatf("current_cycle %0d, want %0d",
                                         rsp_data.current_cycle, want.current_cycle));
            if (rsp_data.phase_left_ms !== want.phase_left_ms)
               report_mismatch($sformatf("phase_left_ms %0d, want %0d",
                                         rsp_data.phase_left_ms, want.phase_left_ms));
            if (rsp_data.phase_length_ms !== want.phase_length_ms)
               report_mismatch($sformatf("phase_length_ms %0d, want %0d",
                                         rsp_data.phase_length_ms, want.phase_length_ms));
            if (rsp_data.caption_left_ms !== want.caption_left_ms)
               report_mismatch($sformatf("caption_left_ms %0d, want %0d",
                                         rsp_data.caption_left_ms, want.caption_left_ms));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      bit in_regs;
      int sender_idle [4];
      int recv_stall  [4];
      sender_idle = '{0, 50, 0, 21};
      recv_stall  = '{0, 0, 50, 21};

      cycle_secs[0] = CYCLE0_RESET;
      cycle_secs[1] = CYCLE1_RESET;
      cycle_secs[2] = CYCLE2_RESET;
      cycle_secs[3] = CYCLE3_RESET;
      ready_secs    = READY_RESET;
      caption_len   = CAPTION_RESET;
      m_phase       = PH_IDLE;
      m_cycle       = '0;
      m_running     = 1'b0;
      m_left        = 0;
      m_caption     = 0;

      // default durations: ready 3 s, cycle 0 inhale 2 s
      plan_check(OP_TICK, 16'h0000, shown(PH_IDLE, 1'b0, 2'd0, 18'd0, 18'd0, 16'd0));
      plan_check(OP_TICK, 16'hFFFF, shown(PH_IDLE, 1'b0, 2'd0, 18'd0, 18'd0, 16'd0));
      plan_check(OP_TAP,  16'h0000,
                 shown(PH_READY, 1'b1, 2'd0, 18'd3000, 18'd3000, 16'd0));
      plan_check(OP_TAP,  16'h0000,
                 shown(PH_READY, 1'b0, 2'd0, 18'd3000, 18'd3000, 16'd0));
      plan_check(OP_TICK, 16'hFFFF,
                 shown(PH_READY, 1'b0, 2'd0, 18'd3000, 18'd3000, 16'd0));
      plan_check(OP_TAP,  16'hFFFF,
                 shown(PH_READY, 1'b1, 2'd0, 18'd3000, 18'd3000, 16'd0));
      plan_check(OP_TICK, 16'd2999,
                 shown(PH_READY, 1'b1, 2'd0, 18'd1, 18'd3000, 16'd0));
      plan_check(OP_TICK, 16'd1,
                 shown(PH_INHALE, 1'b1, 2'd0, 18'd2000, 18'd2000, 16'd0));
      plan_item(OP_TICK, 16'hFFFF);    // runs off the end, surplus dropped
      plan_item(OP_TICK, 16'd500);
      plan_item(OP_TAP,  16'h5A5A);    // restart while the caption still counts
      plan_item(OP_TICK, 16'd1000);
      plan_item(OP_TICK, 16'hFFFF);
      plan_item(OP_TICK, 16'hFFFF);    // caption saturates at zero
      // all phases zero length
      plan_reg(CSR_CYCLE0, 24'h000000);
      plan_reg(CSR_CYCLE1, 24'h000000);
      plan_reg(CSR_CYCLE2, 24'h000000);
      plan_reg(CSR_CYCLE3, 24'h000000);
      plan_reg(CSR_READY, 24'h000000);
      plan_reg(CSR_CAPTION, 24'hFFFFFF);
      plan_reg(CSR_SPARE_LO, 24'hFFFFFF);
      plan_reg(CSR_SPARE_HI, 24'($urandom));
      plan_item(OP_TAP,  16'h0000);
      plan_item(OP_TICK, 16'h0000);
      plan_item(OP_TICK, 16'h0001);
      // longest phases
      plan_reg(CSR_CYCLE0, 24'hFFFFFF);
      plan_reg(CSR_CYCLE1, 24'hFFFFFF);
      plan_reg(CSR_CYCLE2, 24'hFFFFFF);
      plan_reg(CSR_CYCLE3, 24'hFFFFFF);
      plan_reg(CSR_READY, 24'h0000FF);
      plan_reg(CSR_CAPTION, 24'h000000);
      plan_item(OP_TAP,  16'h0000);
      plan_item(OP_TICK, 16'hFFFF);
      plan_item(OP_TAP,  16'h0000);
      plan_item(OP_TICK, 16'hFFFF);
      plan_item(OP_TAP,  16'h0000);
      plan_item(OP_TICK, 16'hFFFF);
      plan_item(OP_TICK, 16'hFFFF);
      plan_item(OP_TICK, 16'hFFFF);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      in_regs = 1'b0;
      foreach (plan[k]) begin
         if (plan[k].is_reg) begin
            if (!in_regs)
               hold_off();
            in_regs = 1'b1;
            write_reg(plan[k].idx, plan[k].val);
         end else begin
            in_regs = 1'b0;
            send_item(plan[k].item, plan[k].typed, plan[k].want);
         end
      end

      for (int p = 0; p < 4; p++) begin
         hold_off();
         idle_pct  = sender_idle[p];
         stall_pct = recv_stall[p];
         write_reg(CSR_CYCLE0, rand_cycle_word(p == 2));
         write_reg(CSR_CYCLE1, rand_cycle_word(p == 2));
         write_reg(CSR_CYCLE2, rand_cycle_word(p == 2));
         write_reg(CSR_CYCLE3, rand_cycle_word(p == 2));
         write_reg(CSR_READY, (p == 2) ? 24'($urandom) : 24'($urandom_range(0, 4)));
         write_reg(CSR_CAPTION, 24'($urandom));
         write_reg((p % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, 24'($urandom));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2)
               hold_off();
            send_item(next_random_item(), 1'b0, '0);
         end
      end

      hold_off();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (status_due.size() != 0)
         report_mismatch($sformatf("%0d status beats never arrived", status_due.size()));
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* breathing_phase_sequencer_timer.f */
hw/rtl/bpst_pkg.sv
hw/rtl/bpst_ctrl.sv
hw/rtl/bpst_datapath.sv
hw/rtl/breathing_phase_sequencer_timer.sv
tb/breathing_phase_sequencer_timer_test.sv
